@@ design/assert_macros.svh @@
// Assertion macros for the RTL of byte_ring_queue_word_access.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/brq_pkg.sv @@
// Package for the byte ring queue: sizes, command codes and sequencer states.
// No dependencies; imported by byte_ring_queue_word_access and its testbench.
package brq_pkg;

   // Store depth; pointers wrap by truncation, so this is a power of two.
   localparam int STORE_SLOTS    = 4096;
   localparam int PTR_W          = $clog2(STORE_SLOTS);
   localparam int MAX_WORD_BYTES = 8;
   localparam int CNT_W          = $clog2(MAX_WORD_BYTES + 1);
   localparam int SEL_W          = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;

   // Fixed field widths of the stream payloads.
   localparam int CMD_W   = 3;
   localparam int WORD_W  = 64;
   localparam int FIELD_W = 12;
   localparam int CMP_W   = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;
   localparam int REQ_W   = 96;
   localparam int RSP_W   = 96;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_PEEK_AT = 3'd3,
      CMD_SKIP    = 3'd4,
      CMD_CLEAR   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

@@ design/byte_ring_queue_word_access.sv @@
// Byte ring queue with word access. Commands arrive as one transaction each on the
// req_ stream and each gives exactly one response transaction on the rsp_ stream:
// push up to 8 bytes of a word (most significant byte first), pop or peek up to 8
// bytes into a zero-extended big-endian word, peek one byte at an offset from the
// head, skip bytes, or clear. A command succeeds whole or changes nothing; the
// response carries ok, the read word (zero unless a read succeeded), and the fill
// level and free space after the command. The store has 4096 byte slots, one slot
// always empty. All bytes live in a single byte-wide synchronous RAM with one
// access per cycle, so a command walks its bytes one per cycle. Commands are
// handled one at a time; a finished response waits in an output register, so the
// next command is taken while the response is still unclaimed. The RAM needs no
// clearing after reset: only bytes that were pushed are ever read.
module byte_ring_queue_word_access (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [2:0] command, [66:3] write_data, [78:67] count, [90:79] offset, [95:91] zero
   input  logic [brq_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] ok, [64:1] read_value, [76:65] fill_level, [88:77] free_space, [95:89] zero
   output logic [brq_pkg::RSP_W-1:0]   rsp_tdata
);
   import brq_pkg::*;

   `include "assert_macros.svh"

   // Request fields
   logic [CMD_W-1:0]   req_cmd;
   logic [WORD_W-1:0]  req_wdata;
   logic [FIELD_W-1:0] req_count;
   logic [FIELD_W-1:0] req_offset;

   assign req_cmd    = req_tdata[2:0];
   assign req_wdata  = req_tdata[66:3];
   assign req_count  = req_tdata[78:67];
   assign req_offset = req_tdata[90:79];

   // Control state
   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rd_vld_ff, rd_vld_in;   // RAM read data valid this cycle

   // Per-command working registers
   logic [PTR_W-1:0]  base_ff, base_in;       // first RAM slot of the transfer
   logic [CNT_W-1:0]  n_ff, n_in;             // bytes to move
   logic [CNT_W-1:0]  idx_ff, idx_in;         // byte being moved
   logic [WORD_W-1:0] wdata_ff, wdata_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic              ok_ff, ok_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // Byte RAM
   logic [7:0]        mem [STORE_SLOTS];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_addr;
   logic [SEL_W-1:0]  byte_sel;
   logic [7:0]        wr_byte;

   // Occupancy from the current pointers
   logic [PTR_W-1:0]  fill;
   logic [PTR_W-1:0]  free;
   logic [CMP_W-1:0]  fill_cmp, free_cmp, count_cmp, offset_cmp;
   logic              count_small;
   logic              last_byte;

   assign fill        = wr_ptr_ff - rd_ptr_ff;
   assign free        = PTR_W'(STORE_SLOTS - 1) - fill;
   assign fill_cmp    = CMP_W'(fill);
   assign free_cmp    = CMP_W'(free);
   assign count_cmp   = CMP_W'(req_count);
   assign offset_cmp  = CMP_W'(req_offset);
   assign count_small = (req_count <= FIELD_W'(MAX_WORD_BYTES));
   assign last_byte   = (idx_ff == n_ff - CNT_W'(1));

   // Push sends the most significant of the n bytes first
   assign mem_addr = base_ff + PTR_W'(idx_ff);
   assign byte_sel = SEL_W'(n_ff - CNT_W'(1) - idx_ff);
   assign wr_byte  = wdata_ff[{byte_sel, 3'b000} +: 8];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= wr_byte;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      wdata_in     = wdata_ff;
      ok_in        = ok_ff;
      value_in     = value_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_vld_in    = (state_ff == ST_READ);
      mem_we       = 1'b0;
      req_tready   = (state_ff == ST_IDLE);

      // RAM data arrives in the cycle after its address; shift it in big-endian
      if (rd_vld_ff) begin
         value_in = {value_ff[WORD_W-9:0], rd_data_ff};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               wdata_in = req_wdata;
               idx_in   = '0;
               n_in     = req_count[CNT_W-1:0];
               value_in = '0;
               ok_in    = 1'b0;
               base_in  = rd_ptr_ff;
               state_in = ST_DONE;
               unique case (req_cmd)
                  CMD_PUSH: begin
                     if (count_small && count_cmp <= free_cmp) begin
                        ok_in     = 1'b1;
                        base_in   = wr_ptr_ff;
                        wr_ptr_in = wr_ptr_ff + PTR_W'(req_count);
                        if (req_count != '0) begin
                           state_in = ST_WRITE;
                        end
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (count_small && count_cmp <= fill_cmp) begin
                        ok_in = 1'b1;
                        if (req_cmd == CMD_POP) begin
                           rd_ptr_in = rd_ptr_ff + PTR_W'(req_count);
                        end
                        if (req_count != '0) begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  CMD_PEEK_AT: begin
                     if (offset_cmp < fill_cmp) begin
                        ok_in    = 1'b1;
                        base_in  = rd_ptr_ff + PTR_W'(req_offset);
                        n_in     = CNT_W'(1);
                        state_in = ST_READ;
                     end
                  end
                  CMD_SKIP: begin
                     ok_in = 1'b1;
                     if (count_cmp >= fill_cmp) begin
                        rd_ptr_in = wr_ptr_ff;
                     end else begin
                        rd_ptr_in = rd_ptr_ff + PTR_W'(req_count);
                     end
                  end
                  CMD_CLEAR: begin
                     ok_in     = 1'b1;
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            idx_in = idx_ff + CNT_W'(1);
            if (last_byte) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            idx_in = idx_ff + CNT_W'(1);
            if (last_byte) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last byte lands in value_ff on this edge
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {7'd0, FIELD_W'(free), FIELD_W'(fill), value_ff, ok_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      wdata_ff    <= wdata_in;
      value_ff    <= value_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A refused command never reports read data
   `ASSERT_CLK(a_refused_zero, clock, reset, (state_ff == ST_DONE && !ok_ff) |-> (value_ff == '0), "refused command carries read data")
   // Byte transfers only run for a nonzero count within the word size
   `ASSERT_CLK(a_xfer_count, clock, reset, (state_ff == ST_WRITE || state_ff == ST_READ) |-> (n_ff != '0 && n_ff <= CNT_W'(MAX_WORD_BYTES)), "transfer with bad byte count")
   // The byte index of a RAM write never passes the transfer length
   `ASSERT_NEVER(a_idx_range, clock, reset, mem_we && idx_ff >= n_ff, "RAM write beyond transfer length")
   // The last read byte is in flight when draining
   `ASSERT_CLK(a_drain_data, clock, reset, (state_ff == ST_DRAIN) |-> rd_vld_ff, "drain without pending RAM data")

endmodule

@@ verif/tb_byte_ring_queue_word_access.sv @@
// Self-checking testbench for byte_ring_queue_word_access: directed table, then biased random.
// Depends on brq_pkg and the byte_ring_queue_word_access RTL; reads no files.
// Expected responses come from an in-bench model of the byte queue.
module tb_byte_ring_queue_word_access;
   timeunit 1ns;
   timeprecision 1ps;

   import brq_pkg::*;

   // Codes 6 and 7 are not commands; the block must refuse them.
   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

   localparam int RANDOM_ITEMS = 850;
   localparam int IDLE_LIMIT   = 1000;   // cycles with no transaction on either side
   localparam int DRAIN_CYCLES = 16;     // extra wait after the last response, with margin
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [WORD_W-1:0]  write_data;
      logic [FIELD_W-1:0] count;
      logic [FIELD_W-1:0] offset;
   } command_type;

   typedef struct packed {
      logic               ok;
      logic [WORD_W-1:0]  read_value;
      logic [FIELD_W-1:0] fill_level;
      logic [FIELD_W-1:0] free_space;
   } result_type;

   typedef struct packed {
      command_type cmd;
      logic        typed;   // 1: use the response below, 0: take it from the model
      result_type  rsp;
   } directed_row_type;

   localparam result_type NO_RSP = '{1'b0, 64'h0, 12'd0, 12'd0};

   // Directed sequence. Typed responses are the obvious ones: empty queue,
   // refused commands and the first few words.
   localparam directed_row_type DIRECTED_ROWS [0:24] = '{
      // reads on an empty queue
      '{'{CMD_POP,     64'h0, 12'd1,    12'd0},    1'b1, '{1'b0, 64'h0, 12'd0, 12'd4095}},
      '{'{CMD_PEEK,    64'h0, 12'd0,    12'd0},    1'b1, '{1'b1, 64'h0, 12'd0, 12'd4095}},
      '{'{CMD_PEEK_AT, 64'h0, 12'd0,    12'd0},    1'b1, '{1'b0, 64'h0, 12'd0, 12'd4095}},
      '{'{CMD_PEEK_AT, 64'h0, 12'd0,    12'd4094}, 1'b1, '{1'b0, 64'h0, 12'd0, 12'd4095}},
      // count too large, then zero count
      '{'{CMD_PUSH,    ALL_ONES, 12'd9,    12'd0}, 1'b1, '{1'b0, 64'h0, 12'd0, 12'd4095}},
      '{'{CMD_PUSH,    ALL_ONES, 12'd4095, 12'd4094}, 1'b1, '{1'b0, 64'h0, 12'd0, 12'd4095}},
      '{'{CMD_PUSH,    ALL_ONES, 12'd0,    12'd0}, 1'b1, '{1'b1, 64'h0, 12'd0, 12'd4095}},
      // one full word in, read back several ways
      '{'{CMD_PUSH, 64'h0123_4567_89AB_CDEF, 12'd8, 12'd0}, 1'b1,
        '{1'b1, 64'h0, 12'd8, 12'd4087}},
      '{'{CMD_PEEK,    64'h0, 12'd8,    12'd0},    1'b1,
        '{1'b1, 64'h0123_4567_89AB_CDEF, 12'd8, 12'd4087}},
      '{'{CMD_PEEK_AT, 64'h0, 12'd0,    12'd0},    1'b1, '{1'b1, 64'h01, 12'd8, 12'd4087}},
      '{'{CMD_PEEK_AT, 64'h0, 12'd0,    12'd7},    1'b1, '{1'b1, 64'hEF, 12'd8, 12'd4087}},
      '{'{CMD_PEEK_AT, 64'h0, 12'd0,    12'd8},    1'b1, '{1'b0, 64'h0, 12'd8, 12'd4087}},
      '{'{CMD_PUSH,    ALL_ONES, 12'd3, 12'd0},    1'b1, '{1'b1, 64'h0, 12'd11, 12'd4084}},
      '{'{CMD_POP,     64'h0, 12'd9,    12'd0},    1'b1, '{1'b0, 64'h0, 12'd11, 12'd4084}},
      '{'{CMD_POP,     64'h0, 12'd8,    12'd0},    1'b1,
        '{1'b1, 64'h0123_4567_89AB_CDEF, 12'd3, 12'd4092}},
      // not enough data
      '{'{CMD_POP,     64'h0, 12'd4,    12'd0},    1'b1, '{1'b0, 64'h0, 12'd3, 12'd4092}},
      '{'{CMD_PEEK,    64'h0, 12'd3,    12'd0},    1'b1, '{1'b1, 64'hFF_FFFF, 12'd3, 12'd4092}},
      // skip nothing, then skip past the end
      '{'{CMD_SKIP,    64'h0, 12'd0,    12'd0},    1'b1, '{1'b1, 64'h0, 12'd3, 12'd4092}},
      '{'{CMD_SKIP,    64'h0, 12'd4095, 12'd0},    1'b1, '{1'b1, 64'h0, 12'd0, 12'd4095}},
      // unknown codes
      '{'{CMD_RSVD_6,  ALL_ONES, 12'd1, 12'd0},    1'b1, '{1'b0, 64'h0, 12'd0, 12'd4095}},
      '{'{CMD_RSVD_7,  ALL_ONES, 12'd1, 12'd0},    1'b1, '{1'b0, 64'h0, 12'd0, 12'd4095}},
      // clear with data held, then leave the head off slot zero
      '{'{CMD_PUSH,    64'h0, 12'd8,    12'd0},    1'b0, NO_RSP},
      '{'{CMD_CLEAR,   64'h0, 12'd0,    12'd0},    1'b1, '{1'b1, 64'h0, 12'd0, 12'd4095}},
      '{'{CMD_PUSH, 64'h8000_0000_00A5_5A01, 12'd5, 12'd0}, 1'b0, NO_RSP},
      '{'{CMD_POP,     64'h0, 12'd2,    12'd0},    1'b0, NO_RSP}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;

   // Queue model: byte store plus head/tail pointers that wrap by truncation.
   logic [7:0]          queue_bytes [0:STORE_SLOTS-1];
   logic [PTR_W-1:0]    head_ptr = '0;
   logic [PTR_W-1:0]    tail_ptr = '0;

   result_type          awaited_results [$];
   int                  mismatches = 0;
   int                  idle_cycles = 0;

   // Sender pacing
   int                  burst_left = 0;

   // Receiver stall pattern, rotated each cycle and reloaded now and then
   logic [31:0]         ready_pattern = '1;
   int                  pattern_age = 0;

   byte_ring_queue_word_access DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [PTR_W-1:0] stored_bytes();
      return tail_ptr - head_ptr;
   endfunction

   // Applies one command to the queue model and returns the response it gives.
   task automatic apply_queue_command(input command_type c, output result_type r);
      logic [PTR_W-1:0] fill;
      logic [PTR_W-1:0] room;
      fill = stored_bytes();
      room = PTR_W'(STORE_SLOTS - 1) - fill;
      r = '0;
      case (c.command)
         CMD_PUSH: begin
            if (c.count <= MAX_WORD_BYTES && c.count <= room) begin
               // most significant of the low count bytes goes in first
               for (int i = 0; i < c.count; i++)
                  queue_bytes[PTR_W'(tail_ptr + i)] = 8'(c.write_data >> (8 * (c.count - 1 - i)));
               tail_ptr = tail_ptr + PTR_W'(c.count);
               r.ok = 1'b1;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (c.count <= MAX_WORD_BYTES && c.count <= fill) begin
               for (int i = 0; i < c.count; i++)
                  r.read_value = {r.read_value[WORD_W-9:0], queue_bytes[PTR_W'(head_ptr + i)]};
               if (c.command == CMD_POP)
                  head_ptr = head_ptr + PTR_W'(c.count);
               r.ok = 1'b1;
            end
         end
         CMD_PEEK_AT: begin
            if (c.offset < fill) begin
               r.read_value = WORD_W'(queue_bytes[PTR_W'(head_ptr + c.offset)]);
               r.ok = 1'b1;
            end
         end
         CMD_SKIP: begin
            // skipping past the end just empties the queue
            if (c.count >= fill)
               head_ptr = tail_ptr;
            else
               head_ptr = head_ptr + PTR_W'(c.count);
            r.ok = 1'b1;
         end
         CMD_CLEAR: begin
            head_ptr = '0;
            tail_ptr = '0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.fill_level = FIELD_W'(stored_bytes());
      r.free_space = FIELD_W'(PTR_W'(STORE_SLOTS - 1) - stored_bytes());
   endtask

   // Random command. While filling, mostly full-word pushes so the queue
   // reaches full and the pointers wrap; while draining, mostly reads and skips.
   function automatic command_type pick_command(input bit filling);
      command_type c;
      int pick;
      int fill;
      fill = int'(stored_bytes());
      pick = $urandom_range(0, 99);
      c.write_data = {$urandom, $urandom};
      c.offset = FIELD_W'($urandom_range(0, 4094));
      c.count = FIELD_W'($urandom_range(0, MAX_WORD_BYTES));
      if (filling) begin
         if (pick < 78) begin
            c.command = CMD_PUSH;
            if ($urandom_range(0, 4) != 0)
               c.count = FIELD_W'(MAX_WORD_BYTES);
         end else if (pick < 82) begin
            c.command = ($urandom_range(0, 2) == 0) ? CMD_PUSH : CMD_POP;
            c.count = ($urandom_range(0, 3) == 0) ? 12'd4095 : FIELD_W'($urandom_range(9, 4095));
         end else if (pick < 86) c.command = CMD_POP;
         else if (pick < 90) c.command = CMD_PEEK;
         else if (pick < 94) c.command = CMD_PEEK_AT;
         else if (pick < 99) c.command = CMD_SKIP;
         else c.command = ($urandom_range(0, 1) == 0) ? CMD_RSVD_6 : CMD_RSVD_7;
      end else begin
         if (pick < 35) c.command = CMD_POP;
         else if (pick < 55) c.command = CMD_PEEK;
         else if (pick < 70) begin
            c.command = CMD_PEEK_AT;
            pick = $urandom_range(0, 99);
            // mostly inside the data, some exactly at the end
            if (pick < 60 && fill > 0)
               c.offset = FIELD_W'($urandom_range(0, fill - 1));
            else if (pick < 75)
               c.offset = FIELD_W'((fill > 4094) ? 4094 : fill);
         end else if (pick < 80) begin
            c.command = CMD_SKIP;
            c.count = ($urandom_range(0, 4) == 0) ? FIELD_W'($urandom_range(0, 4095))
                                                  : FIELD_W'($urandom_range(0, 64));
         end else if (pick < 88) c.command = CMD_PUSH;
         else if (pick < 93) begin
            c.command = ($urandom_range(0, 1) == 0) ? CMD_PEEK : CMD_PUSH;
            c.count = FIELD_W'($urandom_range(9, 4095));
         end else if (pick < 96) c.command = CMD_CLEAR;
         else c.command = ($urandom_range(0, 1) == 0) ? CMD_RSVD_6 : CMD_RSVD_7;
      end
      return c;
   endfunction

   // Bursts of random length with random gaps; now and then a long burst
   // with no gaps at all.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      end
      burst_left--;
   endtask

   // Presents one command and holds it until the transaction completes.
   // tready is sampled at the falling edge, where nothing is in motion.
   task automatic send_command(input command_type c, input logic typed,
                               input result_type typed_rsp);
      result_type predicted;
      logic       taken;
      pace_sender();
      req_tvalid <= 1'b1;
      // zero pad, offset, count, write_data, command
      req_tdata  <= {5'b0, c.offset, c.count, c.write_data, c.command};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      apply_queue_command(c, predicted);
      awaited_results.push_back(typed ? typed_rsp : predicted);
   endtask

   // Receiver: stall pattern of its own, independent of the sender.
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         ready_pattern <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
         pattern_age   <= $urandom_range(16, 96);
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
         pattern_age   <= pattern_age - 1;
      end
      rsp_tready <= ready_pattern[0];
   end

   // Response check and watchdog, at the falling edge so both handshake
   // sides are settled. A transaction seen here completes at the next rise.
   always @(negedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            // ok, read_value, fill_level, free_space from bit 0 up
            got = {rsp_tdata[0], rsp_tdata[64:1], rsp_tdata[76:65], rsp_tdata[88:77]};
            if (awaited_results.size() == 0) begin
               $display("%0t: response with no command outstanding, expected none actual %h",
                        $realtime, got);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (got.ok !== want.ok) begin
                  $display("%0t: ok expected %0b actual %0b", $realtime, want.ok, got.ok);
                  mismatches++;
               end
               if (got.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %h actual %h", $realtime,
                           want.read_value, got.read_value);
                  mismatches++;
               end
               if (got.fill_level !== want.fill_level) begin
                  $display("%0t: fill_level expected %0d actual %0d", $realtime,
                           want.fill_level, got.fill_level);
                  mismatches++;
               end
               if (got.free_space !== want.free_space) begin
                  $display("%0t: free_space expected %0d actual %0d", $realtime,
                           want.free_space, got.free_space);
                  mismatches++;
               end
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("byte_ring_queue_word_access test failed");
            $finish;
         end
      end
   end

   initial begin
      bit filling;
      filling = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i])
         send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);

      // Fill to full (pointers wrap, pushes get refused), drain, repeat.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (filling && (STORE_SLOTS - 1 - int'(stored_bytes())) < MAX_WORD_BYTES
             && $urandom_range(0, 5) == 0)
            filling = 1'b0;
         else if (!filling && stored_bytes() < MAX_WORD_BYTES)
            filling = 1'b1;
         send_command(pick_command(filling), 1'b0, NO_RSP);
      end
      req_tvalid <= 1'b0;

      // watchdog bounds both waits
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("byte_ring_queue_word_access test passed");
      else
         $display("byte_ring_queue_word_access test failed");
      $finish;
   end

endmodule

@@ byte_ring_queue_word_access.f @@
+incdir+design
design/brq_pkg.sv
design/byte_ring_queue_word_access.sv
verif/tb_byte_ring_queue_word_access.sv
